// ===== hw/rtl/rotenc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rotenc_pkg;

    // Data path width of the counts and of the Q16.16 output.
    localparam int unsigned DATA_W = 32;

    // Width of the configuration register index.
    localparam int unsigned CFG_IDX_W = 2;

    // Item opcodes.
    localparam logic OP_SCAN   = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;

    // Configuration reset values.
    localparam logic signed [DATA_W-1:0] STEP_RESET = 32'sd65536;
    localparam logic signed [DATA_W-1:0] MIN_RESET  = 32'sd0;
    localparam logic signed [DATA_W-1:0] MAX_RESET  = 32'sh7FFF_FFFF;

    // Low-pass filter coefficient is 2^-LP_SHIFT.
    localparam int unsigned LP_SHIFT = 3;

    // Snapshot of the tracking state after one item, passed to the scaler.
    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] count;
        logic signed [DATA_W-1:0] lowpass;
    } t_track;

endpackage

`default_nettype wire

// ===== hw/rtl/rotenc_track.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rotenc_track (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic                 i_opcode,
    input  wire logic                 i_pin_level_a,
    input  wire logic                 i_pin_level_b,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output rotenc_pkg::t_track        o_item
);

    logic [1:0] r_prev;
    logic [1:0] n_prev;
    logic [1:0] r_filt;
    logic [1:0] n_filt;
    logic [1:0] raw;
    logic signed [rotenc_pkg::DATA_W-1:0] r_count;
    logic signed [rotenc_pkg::DATA_W-1:0] n_count;
    logic signed [rotenc_pkg::DATA_W-1:0] r_lowpass;
    logic signed [rotenc_pkg::DATA_W-1:0] n_lowpass;
    logic signed [rotenc_pkg::DATA_W-1:0] diff;
    logic                                 r_vld;
    logic                                 n_vld;
    logic                                 accept;
    rotenc_pkg::t_track                   r_item;

    assign o_stall = r_vld && i_stall;
    assign accept  = i_valid && !o_stall;
    assign n_vld   = accept || (r_vld && i_stall);

    // Pins are active low; A lands in bit 1, B in bit 0.
    assign raw  = {~i_pin_level_a, ~i_pin_level_b};
    assign diff = r_count - r_lowpass;

    always_comb begin
        n_prev    = r_prev;
        n_filt    = r_filt;
        n_count   = r_count;
        n_lowpass = r_lowpass;
        if (i_opcode == rotenc_pkg::OP_UPDATE) begin
            n_lowpass = r_lowpass + (diff >>> rotenc_pkg::LP_SHIFT);
        end else begin
            // A bit flips only when the last two raw samples agree on it.
            n_prev = raw;
            n_filt = (r_filt & (r_prev | raw)) | (r_prev & raw);
            if ((n_filt != r_filt) && n_filt[0]) begin
                n_count = n_filt[1] ? (r_count + 32'sd1) : (r_count - 32'sd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_filt    <= '0;
            r_count   <= '0;
            r_lowpass <= '0;
            r_vld     <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (accept) begin
                r_prev    <= n_prev;
                r_filt    <= n_filt;
                r_count   <= n_count;
                r_lowpass <= n_lowpass;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op      <= i_opcode;
            r_item.count   <= n_count;
            r_item.lowpass <= n_lowpass;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

    a_update_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_opcode == rotenc_pkg::OP_UPDATE))
        |=> ($stable(r_count) && $stable(r_filt) && $stable(r_prev)))
        else $error("update transaction changed the encoder count or filter");

    a_idle_keeps_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> ($stable(r_count) && $stable(r_lowpass)))
        else $error("tracking state changed without an accepted transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/rotenc_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rotenc_scale (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire rotenc_pkg::t_track                  i_item,
    input  wire logic signed [rotenc_pkg::DATA_W-1:0] i_step,
    input  wire logic signed [rotenc_pkg::DATA_W-1:0] i_min,
    input  wire logic signed [rotenc_pkg::DATA_W-1:0] i_max,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [rotenc_pkg::DATA_W-1:0]     o_click_count,
    output logic signed [rotenc_pkg::DATA_W-1:0]     o_smoothed_count,
    output logic signed [rotenc_pkg::DATA_W-1:0]     o_scaled_value
);

    logic                                 r_s2_vld;
    logic                                 n_s2_vld;
    rotenc_pkg::t_track                   r_s2;
    logic signed [rotenc_pkg::DATA_W-1:0] r_s2_prod;
    logic signed [rotenc_pkg::DATA_W-1:0] n_prod;
    logic                                 r_o_vld;
    rotenc_pkg::t_track                   r_o_item;
    logic signed [rotenc_pkg::DATA_W-1:0] r_scaled;
    logic signed [rotenc_pkg::DATA_W-1:0] n_scaled;
    logic signed [rotenc_pkg::DATA_W-1:0] clamped;
    logic                                 adv3;
    logic                                 load2;
    logic                                 load3;

    assign adv3     = !r_o_vld || !i_stall;
    assign o_stall  = r_s2_vld && !adv3;
    assign load2    = i_valid && !o_stall;
    assign load3    = adv3 && r_s2_vld;
    assign n_s2_vld = load2 || (r_s2_vld && !adv3);

    // Only the low word of the product is kept.
    assign n_prod = rotenc_pkg::DATA_W'(i_item.lowpass * i_step);

    // Upper clamp first, then lower clamp, so the minimum wins on overlap.
    always_comb begin
        clamped = r_s2_prod;
        if (clamped > i_max) begin
            clamped = i_max;
        end
        if (clamped < i_min) begin
            clamped = i_min;
        end
        n_scaled = (r_s2.op == rotenc_pkg::OP_UPDATE) ? clamped : r_scaled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
            r_scaled <= '0;
        end else begin
            r_s2_vld <= n_s2_vld;
            if (adv3) begin
                r_o_vld <= r_s2_vld;
            end
            if (load3) begin
                r_scaled <= n_scaled;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load2) begin
            r_s2      <= i_item;
            r_s2_prod <= n_prod;
        end
        if (load3) begin
            r_o_item <= r_s2;
        end
    end

    assign o_valid          = r_o_vld;
    assign o_click_count    = r_o_item.count;
    assign o_smoothed_count = r_o_item.lowpass;
    assign o_scaled_value   = r_scaled;

    a_scan_holds_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load3 && (r_s2.op == rotenc_pkg::OP_SCAN)) |=> $stable(r_scaled))
        else $error("scan transaction changed the scaled output");

    a_update_above_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load3 && (r_s2.op == rotenc_pkg::OP_UPDATE))
        |=> (r_scaled >= $signed($past(i_min))))
        else $error("scaled output fell below the lower clamp");

    a_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && !adv3) |=> (r_s2_vld && $stable(r_s2_prod)))
        else $error("product stage lost or changed a stalled transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/rotary_encoder_filtered_position.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rotary encoder front end with a smoothed, scaled position. Each accepted
// transaction is either a pin scan (opcode 0), which deglitches the two
// active-low encoder pins and steps the click count, or an update (opcode 1),
// which moves the smoothed count one eighth of the way toward the click count
// and rescales it by the Q16.16 step, clamped to [minimum, maximum] with the
// minimum winning if the two overlap. Every transaction returns exactly one
// result carrying the click count, smoothed count and last scaled value.
// A new transaction is taken every cycle while the result side does not stall;
// each transaction passes through the encoder and filter state update, the 32
// by 32 multiply and the clamp into the output register, with a register after
// each step. Configuration registers (0 step, 1 minimum, 2 maximum) are
// always ready and must be written only while no transaction is in flight;
// writes to index 3 are ignored.

module rotary_encoder_filtered_position (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // Item input channel.
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic                                  i_opcode,
    input  wire logic                                  i_pin_level_a,
    input  wire logic                                  i_pin_level_b,
    // Result output channel.
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [rotenc_pkg::DATA_W-1:0]       o_click_count,
    output logic signed [rotenc_pkg::DATA_W-1:0]       o_smoothed_count,
    output logic signed [rotenc_pkg::DATA_W-1:0]       o_scaled_value,
    // Configuration write channel.
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [rotenc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic signed [rotenc_pkg::DATA_W-1:0]  i_cfg_data
);

    logic signed [rotenc_pkg::DATA_W-1:0] r_step;
    logic signed [rotenc_pkg::DATA_W-1:0] r_min;
    logic signed [rotenc_pkg::DATA_W-1:0] r_max;
    logic                                 track_valid;
    logic                                 track_stall;
    rotenc_pkg::t_track                   track_item;

    // The register file never pushes back.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= rotenc_pkg::STEP_RESET;
            r_min  <= rotenc_pkg::MIN_RESET;
            r_max  <= rotenc_pkg::MAX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rotenc_pkg::CFG_STEP: r_step <= i_cfg_data;
                rotenc_pkg::CFG_MIN:  r_min  <= i_cfg_data;
                rotenc_pkg::CFG_MAX:  r_max  <= i_cfg_data;
                default: begin
                    // Unmapped index: the write is dropped.
                end
            endcase
        end
    end

    // Pin filter, click counter and low-pass state; registers a snapshot
    // of the state after each transaction.
    rotenc_track u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_pin_level_a (i_pin_level_a),
        .i_pin_level_b (i_pin_level_b),
        .o_valid       (track_valid),
        .i_stall       (track_stall),
        .o_item        (track_item)
    );

    // Multiply and clamp stages feeding the output register.
    rotenc_scale u_scale (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (track_valid),
        .o_stall          (track_stall),
        .i_item           (track_item),
        .i_step           (r_step),
        .i_min            (r_min),
        .i_max            (r_max),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_click_count    (o_click_count),
        .o_smoothed_count (o_smoothed_count),
        .o_scaled_value   (o_scaled_value)
    );

endmodule

`default_nettype wire

// ===== sim/rotary_encoder_filtered_position_checker.sv =====
`timescale 1ns / 1ps

// Watches the item, result and configuration channels of the encoder front
// end, keeps its own copy of the tracking state and compares every result.
module rotary_encoder_filtered_position_checker
    import rotenc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    input  wire logic                     i_in_stall,
    input  wire logic                     i_opcode,
    input  wire logic                     i_pin_level_a,
    input  wire logic                     i_pin_level_b,
    input  wire logic                     i_out_valid,
    input  wire logic                     i_out_stall,
    input  wire logic signed [DATA_W-1:0] i_click_count,
    input  wire logic signed [DATA_W-1:0] i_smoothed_count,
    input  wire logic signed [DATA_W-1:0] i_scaled_value,
    input  wire logic                     i_cfg_valid,
    input  wire logic                     i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic signed [DATA_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] clicks;
        logic signed [DATA_W-1:0] smooth;
        logic signed [DATA_W-1:0] scaled;
    } t_position;

    t_position expected_positions[$];

    logic signed [DATA_W-1:0] step_cfg;
    logic signed [DATA_W-1:0] min_cfg;
    logic signed [DATA_W-1:0] max_cfg;

    logic [1:0]               prev_raw;
    logic [1:0]               filt_code;
    logic signed [DATA_W-1:0] clicks;
    logic signed [DATA_W-1:0] smooth;
    logic signed [DATA_W-1:0] scaled;

    initial o_fail_count = 0;
    initial o_pending = 0;

    // Every mismatch prints one line and is counted.
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        o_fail_count = o_fail_count + 1;
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task automatic track_encoder(input logic op, input logic pa, input logic pb);
        logic [1:0]               raw;
        logic [1:0]               nxt;
        logic signed [DATA_W-1:0] diff;
        logic signed [DATA_W-1:0] product;
        if (op == OP_UPDATE) begin
            diff = clicks - smooth;
            smooth = smooth + (diff >>> LP_SHIFT);
            product = smooth * step_cfg;
            if (product > max_cfg)
                product = max_cfg;
            if (product < min_cfg)
                product = min_cfg;
            scaled = product;
        end else begin
            raw = {~pa, ~pb};
            // Each bit follows the majority of its held value and the last
            // two raw samples.
            nxt = (filt_code & (prev_raw | raw)) | (prev_raw & raw);
            if (nxt != filt_code && nxt[0])
                clicks = nxt[1] ? clicks + 1 : clicks - 1;
            filt_code = nxt;
            prev_raw = raw;
        end
    endtask

    always @(posedge i_clk) begin
        t_position want;
        if (!i_rst_n) begin
            step_cfg = STEP_RESET;
            min_cfg = MIN_RESET;
            max_cfg = MAX_RESET;
            prev_raw = 2'b00;
            filt_code = 2'b00;
            clicks = '0;
            smooth = '0;
            scaled = '0;
            expected_positions.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STEP: step_cfg = i_cfg_data;
                    CFG_MIN:  min_cfg = i_cfg_data;
                    CFG_MAX:  max_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                track_encoder(i_opcode, i_pin_level_a, i_pin_level_b);
                expected_positions.push_back('{clicks, smooth, scaled});
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_positions.size() == 0) begin
                    report_mismatch("unexpected result", i_click_count, '0);
                end else begin
                    want = expected_positions.pop_front();
                    if (i_click_count !== want.clicks)
                        report_mismatch("click_count", i_click_count, want.clicks);
                    if (i_smoothed_count !== want.smooth)
                        report_mismatch("smoothed_count", i_smoothed_count, want.smooth);
                    if (i_scaled_value !== want.scaled)
                        report_mismatch("scaled_value", i_scaled_value, want.scaled);
                end
            end
        end
        o_pending <= expected_positions.size();
    end

endmodule

// ===== sim/tb_rotary_encoder_filtered_position.sv =====
`timescale 1ns / 1ps

// Top of the encoder front end testbench. It drives pin scans, updates and
// configuration writes, randomizes idle cycles on both channels, and gives
// the verdict from the checker's failure count and pending results.
module tb_rotary_encoder_filtered_position;
    import rotenc_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic in_valid;
    logic in_stall;
    logic opcode;
    logic pin_a;
    logic pin_b;

    logic                     out_valid;
    logic                     rx_stall = 1'b0;
    logic signed [DATA_W-1:0] click_count;
    logic signed [DATA_W-1:0] smoothed_count;
    logic signed [DATA_W-1:0] scaled_value;

    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic signed [DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;

    // Idle control: percent chance of a gap before an item and of a stall
    // burst on the result side. In the calm part neither side idles.
    int   gap_pct = 0;
    int   stall_pct = 0;
    logic calm = 1'b0;
    int   stall_left = 0;

    // Position of the simulated shaft in the quadrature cycle.
    int   shaft_pos = 0;
    int   phase_items;

    rotary_encoder_filtered_position uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_opcode         (opcode),
        .i_pin_level_a    (pin_a),
        .i_pin_level_b    (pin_b),
        .o_valid          (out_valid),
        .i_stall          (rx_stall),
        .o_click_count    (click_count),
        .o_smoothed_count (smoothed_count),
        .o_scaled_value   (scaled_value),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    rotary_encoder_filtered_position_checker position_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_opcode         (opcode),
        .i_pin_level_a    (pin_a),
        .i_pin_level_b    (pin_b),
        .i_out_valid      (out_valid),
        .i_out_stall      (rx_stall),
        .i_click_count    (click_count),
        .i_smoothed_count (smoothed_count),
        .i_scaled_value   (scaled_value),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The result side stalls in bursts whose length is drawn when they start. A burst
    // starts with the chance set for the current phase.
    always @(posedge i_clk) begin
        if (calm || stall_pct == 0) begin
            rx_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            rx_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < stall_pct) begin
            rx_stall <= 1'b1;
            stall_left <= $urandom_range(5, 0);
        end else begin
            rx_stall <= 1'b0;
        end
    end

    // Offers one transaction and returns at the edge that accepts it. The
    // valid stays high when the next item follows without a gap, so it is
    // only lowered at the start of a gap.
    task automatic send_item(input logic op, input logic a, input logic b);
        if (!calm && $urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        pin_a <= a;
        pin_b <= b;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        phase_items = phase_items + 1;
    endtask

    // The pins are active low, so the decoded code is the inverse of the
    // levels on the wires.
    task automatic scan_code(input logic [1:0] code);
        send_item(OP_SCAN, ~code[1], ~code[0]);
    endtask

    // Pin levels carry random junk on updates, where they must be ignored.
    task automatic send_update();
        send_item(OP_UPDATE, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every expected result has come back, then lets the
    // three-stage pipeline settle a little longer.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // One move of the shaft in a random direction along the Gray sequence
    // 00, 01, 11, 10. The new code is held for two to four samples so the
    // filter takes it, sometimes after a single glitch sample that it must
    // reject. Updates are mixed in now and then.
    task automatic shaft_step();
        logic [1:0] code;
        int         hold;
        if ($urandom_range(1))
            shaft_pos = (shaft_pos + 1) % 4;
        else
            shaft_pos = (shaft_pos + 3) % 4;
        code = {shaft_pos[1], shaft_pos[1] ^ shaft_pos[0]};
        if ($urandom_range(7) == 0)
            scan_code(2'($urandom_range(3)));
        hold = $urandom_range(4, 2);
        repeat (hold) scan_code(code);
        if ($urandom_range(4) == 0)
            send_update();
    endtask

    task automatic run_phase(input logic [DATA_W-1:0] step, input logic [DATA_W-1:0] lo,
                             input logic [DATA_W-1:0] hi, input int count);
        int choice;
        write_reg(CFG_STEP, step);
        write_reg(CFG_MIN, lo);
        write_reg(CFG_MAX, hi);
        phase_items = 0;
        while (phase_items < count) begin
            choice = $urandom_range(9);
            if (choice < 7) begin
                shaft_step();
            end else if (choice == 7) begin
                // Noise: random pin levels with no regard for the sequence.
                repeat ($urandom_range(4, 1))
                    send_item(OP_SCAN, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                repeat ($urandom_range(3, 1)) send_update();
            end
        end
        drain();
    endtask

    initial begin
        int p;
        i_rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= OP_SCAN;
        pin_a <= 1'b1;
        pin_b <= 1'b1;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_STEP;
        cfg_data <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset configuration. An update straight out
        // of reset, then a full cycle of codes with each held two samples:
        // entering 01 counts down, entering 11 counts up.
        gap_pct = 20;
        stall_pct = 20;
        phase_items = 0;
        send_item(OP_UPDATE, 1'b0, 1'b0);
        repeat (2) scan_code(2'b01);
        repeat (2) scan_code(2'b11);
        repeat (2) scan_code(2'b10);
        repeat (2) scan_code(2'b00);
        repeat (2) scan_code(2'b10);
        repeat (2) scan_code(2'b11);
        // A single sample of 01 then 00: both agree on bit 1, so the filter moves to 01 and counts down.
        scan_code(2'b01);
        scan_code(2'b00);
        // Updates with pin levels 11, 10 and 01, which must have no effect on
        // the encoder state.
        send_item(OP_UPDATE, 1'b1, 1'b1);
        send_item(OP_UPDATE, 1'b1, 1'b0);
        send_item(OP_UPDATE, 1'b0, 1'b1);
        drain();

        // The unused register index must not disturb anything.
        write_reg(2'd3, 32'hDEAD_BEEF);

        for (p = 0; p < 7; p++) begin
            gap_pct = (p % 3 == 1) ? 0 : $urandom_range(50, 10);
            stall_pct = (p % 3 == 2) ? 0 : $urandom_range(50, 10);
            case (p)
                // Largest positive step: the product overflows and wraps.
                0: run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 85);
                // Most negative step over the full output range.
                1: run_phase(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 85);
                // Step of -1 LSB (-2^-16 in Q16.16) with a window of -5.0 to 5.0.
                2: run_phase(32'hFFFF_FFFF, 32'hFFFB_0000, 32'h0005_0000, 85);
                // Minimum above maximum: the minimum wins every time.
                3: run_phase(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 85);
                4: run_phase($urandom, $urandom, $urandom, 85);
                5: run_phase(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 85);
                // Last part runs with no idling on either side.
                default: begin
                    calm = 1'b1;
                    run_phase($urandom_range(32'h0010_0000, 1), 32'h8000_0000,
                              $urandom, 85);
                end
            endcase
        end

        if (fail_count == 0 && pending == 0)
            $display("tb_rotary_encoder_filtered_position: PASS");
        else
            $display("tb_rotary_encoder_filtered_position: FAIL");
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial begin
        #4_000_000;
        $display("tb_rotary_encoder_filtered_position: FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rotenc_pkg.sv
hw/rtl/rotenc_track.sv
hw/rtl/rotenc_scale.sv
hw/rtl/rotary_encoder_filtered_position.sv
sim/rotary_encoder_filtered_position_checker.sv
sim/tb_rotary_encoder_filtered_position.sv
